// File: hdl/bpme_pkg.sv
`timescale 1ns / 1ps

package bpme_pkg;

    localparam int ID_W            = 12;
    localparam int RANK_W          = 13;
    localparam int BYTE_W          = 8;
    localparam int KIND_W          = 2;
    localparam int DEF_MERGE_SLOTS = 4096;
    localparam int DEF_MAX_WORD    = 64;
    localparam int S_TDATA_W       = 48;
    localparam int M_TDATA_W       = 16;

    localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RULE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   left_id;
        logic [ID_W-1:0]   right_id;
        logic [ID_W-1:0]   merged_id;
        logic [RANK_W-1:0] rank;
    } t_rule;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_SCAN,
        ST_LD_CHK,
        ST_MG_START,
        ST_MG_P0,
        ST_MG_PRD,
        ST_MG_PLD,
        ST_MG_SCAN,
        ST_MG_CHK,
        ST_MG_NEXT,
        ST_MG_R0,
        ST_MG_RRD,
        ST_MG_RLD,
        ST_EM_RD,
        ST_EM_LD,
        ST_EM_WT
    } t_state;

endpackage

// File: hdl/byte_pair_merge_encoder_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tdata: left_id, right_id, merged_id, byte_value
//                                       tuser: kind, tlast: last_byte
// m_axis    out  tvalid/tready          tdata: token_id, tuser: word_overflow,
//                                       tlast: last_token
//
// A word end runs merge rounds; every adjacent pair is matched by a linear scan over
// the rule RAM. Output sends one token at a time and waits while the sink stalls;
// input is not ready meanwhile, nor during a rule load or the merge rounds.
// Reset is synchronous, active low, and clears state, rule count, rank, word length,
// overflow flag and output valid; the memories keep their contents.
module byte_pair_merge_encoder_top #(
    parameter int MERGE_SLOTS = bpme_pkg::DEF_MERGE_SLOTS,
    parameter int MAX_WORD    = bpme_pkg::DEF_MAX_WORD
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // left_id[11:0], right_id[23:12], merged_id[35:24], byte_value[43:36], zero pad
    input  logic [bpme_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // kind[1:0]
    input  logic [bpme_pkg::KIND_W-1:0]    i_s_axis_tuser,
    input  logic                           i_s_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // token_id[11:0], zero pad
    output logic [bpme_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // word_overflow[0]
    output logic                           o_m_axis_tuser,
    output logic                           o_m_axis_tlast
);

    localparam int ID_W   = bpme_pkg::ID_W;
    localparam int RANK_W = bpme_pkg::RANK_W;
    localparam int CW     = $clog2(MERGE_SLOTS + 1);
    localparam int AW     = $clog2(MERGE_SLOTS);
    localparam int LW     = $clog2(MAX_WORD + 1);
    localparam int TAW    = $clog2(MAX_WORD);

    // memories
    bpme_pkg::t_rule  rule_mem [MERGE_SLOTS];
    logic [ID_W-1:0]  tok_mem  [MAX_WORD];
    bpme_pkg::t_rule  r_rule_q;
    logic [ID_W-1:0]  r_tok_q;

    bpme_pkg::t_state r_state, n_state;
    logic [CW-1:0]     r_count, n_count, r_s, n_s;
    logic [RANK_W-1:0] r_rank, n_rank, r_brank, n_brank;
    logic [LW-1:0]     r_len, n_len, r_i, n_i, r_w, n_w;
    logic              r_ovf, n_ovf, r_found, n_found, r_have, n_have;
    logic [ID_W-1:0]   r_l, n_l, r_r, n_r, r_t, n_t;
    logic [ID_W-1:0]   r_prev, n_prev, r_cur, n_cur;
    logic [ID_W-1:0]   r_bl, n_bl, r_br, n_br, r_bt, n_bt;
    logic              r_ovalid, n_ovalid, r_olast, n_olast, r_ouser, n_ouser;
    logic [ID_W-1:0]   r_odata, n_odata;

    logic              rule_we;
    logic [AW-1:0]     rule_wa, rule_ra;
    bpme_pkg::t_rule   rule_wd;
    logic              tok_we;
    logic [TAW-1:0]    tok_wa, tok_ra;
    logic [ID_W-1:0]   tok_wd;

    logic              s_fire;
    logic [LW-1:0]     len_after;
    logic              q_match_ld, q_match_mg;
    logic [RANK_W-1:0] rank_inc;

    assign s_fire     = i_s_axis_tvalid && o_s_axis_tready;
    assign len_after  = (r_len < LW'(MAX_WORD)) ? r_len + 1'b1 : r_len;
    assign q_match_ld = (r_rule_q.left_id == r_l) && (r_rule_q.right_id == r_r);
    assign q_match_mg = (r_rule_q.left_id == r_prev) && (r_rule_q.right_id == r_cur);
    assign rank_inc   = (r_rank != bpme_pkg::RANK_MAX) ? r_rank + 1'b1 : r_rank;

    // write and read the memories
    always_ff @(posedge i_clk) begin
        if (rule_we) begin
            rule_mem[rule_wa] <= rule_wd;
        end
        r_rule_q <= rule_mem[rule_ra];
        if (tok_we) begin
            tok_mem[tok_wa] <= tok_wd;
        end
        r_tok_q <= tok_mem[tok_ra];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bpme_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (i_s_axis_tuser == bpme_pkg::KIND_RULE) begin
                        n_state = bpme_pkg::ST_LD_SCAN;
                    end else if (i_s_axis_tuser == bpme_pkg::KIND_BYTE && i_s_axis_tlast) begin
                        n_state = (len_after < LW'(2)) ? bpme_pkg::ST_EM_RD
                                                       : bpme_pkg::ST_MG_START;
                    end
                end
            end
            bpme_pkg::ST_LD_SCAN: begin
                n_state = (r_s == r_count) ? bpme_pkg::ST_IDLE : bpme_pkg::ST_LD_CHK;
            end
            bpme_pkg::ST_LD_CHK: begin
                n_state = q_match_ld ? bpme_pkg::ST_IDLE : bpme_pkg::ST_LD_SCAN;
            end
            bpme_pkg::ST_MG_START: n_state = bpme_pkg::ST_MG_P0;
            bpme_pkg::ST_MG_P0:    n_state = bpme_pkg::ST_MG_PRD;
            bpme_pkg::ST_MG_PRD:   n_state = bpme_pkg::ST_MG_PLD;
            bpme_pkg::ST_MG_PLD:   n_state = bpme_pkg::ST_MG_SCAN;
            bpme_pkg::ST_MG_SCAN: begin
                n_state = (r_s == r_count) ? bpme_pkg::ST_MG_NEXT : bpme_pkg::ST_MG_CHK;
            end
            bpme_pkg::ST_MG_CHK: begin
                n_state = q_match_mg ? bpme_pkg::ST_MG_NEXT : bpme_pkg::ST_MG_SCAN;
            end
            bpme_pkg::ST_MG_NEXT: begin
                if (r_i + 1'b1 == r_len) begin
                    n_state = r_found ? bpme_pkg::ST_MG_R0 : bpme_pkg::ST_EM_RD;
                end else begin
                    n_state = bpme_pkg::ST_MG_PRD;
                end
            end
            bpme_pkg::ST_MG_R0: n_state = bpme_pkg::ST_MG_RRD;
            bpme_pkg::ST_MG_RRD: begin
                if (r_i == r_len) begin
                    n_state = ((r_w + LW'(r_have)) < LW'(2)) ? bpme_pkg::ST_EM_RD
                                                            : bpme_pkg::ST_MG_START;
                end else begin
                    n_state = bpme_pkg::ST_MG_RLD;
                end
            end
            bpme_pkg::ST_MG_RLD: n_state = bpme_pkg::ST_MG_RRD;
            bpme_pkg::ST_EM_RD:  n_state = bpme_pkg::ST_EM_LD;
            bpme_pkg::ST_EM_LD:  n_state = bpme_pkg::ST_EM_WT;
            bpme_pkg::ST_EM_WT: begin
                if (i_m_axis_tready) begin
                    n_state = r_olast ? bpme_pkg::ST_IDLE : bpme_pkg::ST_EM_RD;
                end
            end
            default: n_state = bpme_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count  = r_count;
        n_s      = r_s;
        n_rank   = r_rank;
        n_brank  = r_brank;
        n_len    = r_len;
        n_i      = r_i;
        n_w      = r_w;
        n_ovf    = r_ovf;
        n_found  = r_found;
        n_have   = r_have;
        n_l      = r_l;
        n_r      = r_r;
        n_t      = r_t;
        n_prev   = r_prev;
        n_cur    = r_cur;
        n_bl     = r_bl;
        n_br     = r_br;
        n_bt     = r_bt;
        n_ovalid = r_ovalid;
        n_olast  = r_olast;
        n_ouser  = r_ouser;
        n_odata  = r_odata;
        rule_we  = 1'b0;
        rule_wa  = r_s[AW-1:0];
        rule_ra  = r_s[AW-1:0];
        rule_wd  = '{left_id: r_l, right_id: r_r, merged_id: r_t, rank: r_rank};
        tok_we   = 1'b0;
        tok_wa   = r_w[TAW-1:0];
        tok_ra   = r_i[TAW-1:0];
        tok_wd   = r_prev;
        case (r_state)
            bpme_pkg::ST_IDLE: begin
                if (s_fire) begin
                    case (i_s_axis_tuser)
                        bpme_pkg::KIND_CLEAR: begin
                            n_count = '0;
                            n_rank  = '0;
                        end
                        bpme_pkg::KIND_RULE: begin
                            n_l = i_s_axis_tdata[ID_W-1:0];
                            n_r = i_s_axis_tdata[2*ID_W-1:ID_W];
                            n_t = i_s_axis_tdata[3*ID_W-1:2*ID_W];
                            n_s = '0;
                        end
                        bpme_pkg::KIND_BYTE: begin
                            // store the byte, or flag it dropped
                            if (r_len < LW'(MAX_WORD)) begin
                                tok_we = 1'b1;
                                tok_wa = r_len[TAW-1:0];
                                tok_wd = ID_W'(i_s_axis_tdata[3*ID_W+bpme_pkg::BYTE_W-1:3*ID_W]);
                            end else begin
                                n_ovf = 1'b1;
                            end
                            n_len = len_after;
                            n_i   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            bpme_pkg::ST_LD_SCAN: begin
                // no existing pair: append if room
                if (r_s == r_count && r_count < CW'(MERGE_SLOTS)) begin
                    rule_we = 1'b1;
                    rule_wa = r_count[AW-1:0];
                    n_count = r_count + 1'b1;
                    n_rank  = rank_inc;
                end
            end
            bpme_pkg::ST_LD_CHK: begin
                if (q_match_ld) begin
                    rule_we = 1'b1;
                    n_rank  = rank_inc;
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            bpme_pkg::ST_MG_START: begin
                n_found = 1'b0;
                n_i     = '0;
            end
            bpme_pkg::ST_MG_P0: begin
                n_prev = r_tok_q;
                n_i    = LW'(1);
            end
            bpme_pkg::ST_MG_PLD: begin
                n_cur = r_tok_q;
                n_s   = '0;
            end
            bpme_pkg::ST_MG_CHK: begin
                // keep the lowest rank; ties stay with the leftmost pair
                if (q_match_mg) begin
                    if (!r_found || r_rule_q.rank < r_brank) begin
                        n_found = 1'b1;
                        n_brank = r_rule_q.rank;
                        n_bl    = r_rule_q.left_id;
                        n_br    = r_rule_q.right_id;
                        n_bt    = r_rule_q.merged_id;
                    end
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            bpme_pkg::ST_MG_NEXT: begin
                n_prev = r_cur;
                n_i    = r_i + 1'b1;
                if (r_i + 1'b1 == r_len && !r_found) begin
                    n_i = '0;
                end
            end
            bpme_pkg::ST_MG_R0: begin
                n_i    = '0;
                n_w    = '0;
                n_have = 1'b0;
            end
            bpme_pkg::ST_MG_RRD: begin
                // flush the held token at the end of the pass
                if (r_i == r_len) begin
                    tok_we = r_have;
                    n_len  = r_w + LW'(r_have);
                    n_i    = '0;
                end
            end
            bpme_pkg::ST_MG_RLD: begin
                n_i = r_i + 1'b1;
                if (r_have && r_prev == r_bl && r_tok_q == r_br) begin
                    tok_we = 1'b1;
                    tok_wd = r_bt;
                    n_w    = r_w + 1'b1;
                    n_have = 1'b0;
                end else if (r_have) begin
                    tok_we = 1'b1;
                    n_w    = r_w + 1'b1;
                    n_prev = r_tok_q;
                end else begin
                    n_prev = r_tok_q;
                    n_have = 1'b1;
                end
            end
            bpme_pkg::ST_EM_LD: begin
                n_ovalid = 1'b1;
                n_odata  = r_tok_q;
                n_olast  = (r_i + 1'b1 == r_len);
                n_ouser  = r_ovf;
            end
            bpme_pkg::ST_EM_WT: begin
                if (i_m_axis_tready) begin
                    n_ovalid = 1'b0;
                    n_i      = r_i + 1'b1;
                    if (r_olast) begin
                        n_len = '0;
                        n_ovf = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // hold state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bpme_pkg::ST_IDLE;
            r_count  <= '0;
            r_rank   <= '0;
            r_len    <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rank   <= n_rank;
            r_len    <= n_len;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
        end
        r_s     <= n_s;
        r_brank <= n_brank;
        r_i     <= n_i;
        r_w     <= n_w;
        r_found <= n_found;
        r_have  <= n_have;
        r_l     <= n_l;
        r_r     <= n_r;
        r_t     <= n_t;
        r_prev  <= n_prev;
        r_cur   <= n_cur;
        r_bl    <= n_bl;
        r_br    <= n_br;
        r_bt    <= n_bt;
        r_olast <= n_olast;
        r_ouser <= n_ouser;
        r_odata <= n_odata;
    end

    assign o_s_axis_tready = (r_state == bpme_pkg::ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = bpme_pkg::M_TDATA_W'(r_odata);
    assign o_m_axis_tlast  = r_olast;
    assign o_m_axis_tuser  = r_ouser;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int KIND_W    = bpme_pkg::KIND_W;
    localparam int ID_W      = bpme_pkg::ID_W;
    localparam int RANK_W    = bpme_pkg::RANK_W;
    localparam int S_TDATA_W = bpme_pkg::S_TDATA_W;
    localparam int M_TDATA_W = bpme_pkg::M_TDATA_W;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int SLOTS   = bpme_pkg::DEF_MERGE_SLOTS;
    localparam int WORD_MX = bpme_pkg::DEF_MAX_WORD;

    typedef struct {
        logic [ID_W-1:0] tok;
        bit              last;
        bit              ovf;
    } t_token;

    // one row of the directed table; exp_tok < 0 means use the encoder model
    typedef struct {
        logic [KIND_W-1:0] kind;
        int                lid;
        int                rid;
        int                mid;
        int                bval;
        bit                last;
        int                exp_tok;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_valid = 1'b0;
    logic [S_TDATA_W-1:0] s_data = '0;
    logic [KIND_W-1:0]    s_kind = bpme_pkg::KIND_CLEAR;
    logic                 s_last = 1'b0;
    logic                 m_ready = 1'b0;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic                 o_m_axis_tuser;
    logic                 o_m_axis_tlast;

    byte_pair_merge_encoder_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_kind),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    // encoder model state
    logic [ID_W-1:0]   rule_l  [SLOTS];
    logic [ID_W-1:0]   rule_r  [SLOTS];
    logic [ID_W-1:0]   rule_t  [SLOTS];
    logic [RANK_W-1:0] rule_rk [SLOTS];
    int                rule_cnt = 0;
    int                rank_ctr = 0;
    logic [ID_W-1:0]   word_buf [WORD_MX];
    int                word_len = 0;
    bit                word_ovf = 0;

    t_token            token_expect_q[$];
    int                errors = 0;
    int                idle_pct = 0;
    int                stall_pct = 0;
    int                hold_req = 0;
    bit                rst_done = 0;
    logic [ID_W-1:0]   id_pool[$];

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #200_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int find_pair(logic [ID_W-1:0] a, logic [ID_W-1:0] b);
        for (int s = 0; s < rule_cnt; s++)
            if (rule_l[s] == a && rule_r[s] == b) return s;
        return -1;
    endfunction

    // merge lowest-rank pairs until no adjacent pair has a rule
    function automatic void merge_word();
        int best, s, w, i;
        logic [ID_W-1:0] bl, br, bt;
        forever begin
            if (word_len < 2) return;
            best = -1;
            for (i = 0; i + 1 < word_len; i++) begin
                s = find_pair(word_buf[i], word_buf[i+1]);
                if (s >= 0 && (best < 0 || rule_rk[s] < rule_rk[best])) best = s;
            end
            if (best < 0) return;
            bl = rule_l[best];
            br = rule_r[best];
            bt = rule_t[best];
            w = 0;
            i = 0;
            while (i < word_len) begin
                if (i + 1 < word_len && word_buf[i] == bl && word_buf[i+1] == br) begin
                    word_buf[w++] = bt;
                    i += 2;
                end else begin
                    word_buf[w++] = word_buf[i];
                    i += 1;
                end
            end
            word_len = w;
        end
    endfunction

    // advance the encoder model by one accepted item and return any tokens it completes
    function automatic void encode_item(logic [KIND_W-1:0] kind, int lid, int rid, int mid,
                                        int bval, bit last, ref t_token res[$]);
        int s, idx;
        res = {};
        case (kind)
            bpme_pkg::KIND_CLEAR: begin
                rule_cnt = 0;
                rank_ctr = 0;
            end
            bpme_pkg::KIND_RULE: begin
                s = find_pair(ID_W'(lid), ID_W'(rid));
                idx = s;
                if (s < 0 && rule_cnt < SLOTS) begin
                    idx = rule_cnt++;
                    rule_l[idx] = ID_W'(lid);
                    rule_r[idx] = ID_W'(rid);
                end
                if (idx >= 0) begin
                    rule_t[idx]  = ID_W'(mid);
                    rule_rk[idx] = RANK_W'(rank_ctr);
                    if (rank_ctr < int'(bpme_pkg::RANK_MAX)) rank_ctr++;
                end
            end
            bpme_pkg::KIND_BYTE: begin
                if (word_len < WORD_MX) word_buf[word_len++] = ID_W'(bval);
                else word_ovf = 1;
                if (last) begin
                    merge_word();
                    for (int k = 0; k < word_len; k++)
                        res = {res, t_token'{word_buf[k], k + 1 == word_len, word_ovf}};
                    word_len = 0;
                    word_ovf = 0;
                end
            end
            default: ;
        endcase
    endfunction

    // offer one item, hold until accepted, then record its expected tokens
    task automatic send(logic [KIND_W-1:0] kind, int lid, int rid, int mid, int bval,
                        bit last, int exp_tok = -1);
        t_token res[$];
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_last  <= last;
        s_data  <= {4'b0, bval[7:0], mid[11:0], rid[11:0], lid[11:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        encode_item(kind, lid, rid, mid, bval, last, res);
        if (exp_tok >= 0)
            token_expect_q = {token_expect_q, t_token'{ID_W'(exp_tok), 1'b1, 1'b0}};
        else
            token_expect_q = {token_expect_q, res};
    endtask

    task automatic send_word(int len, bit small_alpha);
        int b;
        for (int k = 0; k < len; k++) begin
            b = small_alpha ? $urandom_range(8'h66, 8'h61) : $urandom_range(255);
            send(bpme_pkg::KIND_BYTE, $urandom_range(4095), $urandom_range(4095),
                 $urandom_range(4095), b, k == len - 1);
        end
    endtask

    function automatic int pick_id();
        if ($urandom_range(3) == 0 || id_pool.size() == 0) return $urandom_range(4095);
        return int'(id_pool[$urandom_range(id_pool.size() - 1)]);
    endfunction

    // receive side: stall at random, hold off on request, check each token
    always @(posedge i_clk) begin
        static int hold_left = 0;
        static int hold_ack = 0;
        t_token e;
        if (rst_done && o_m_axis_tvalid && m_ready) begin
            if (token_expect_q.size() == 0) begin
                $display("%0t unexpected token: got id %h last %b ovf %b", $time,
                         o_m_axis_tdata, o_m_axis_tlast, o_m_axis_tuser);
                errors++;
            end else begin
                e = token_expect_q.pop_front();
                if (o_m_axis_tdata !== {4'b0, e.tok} || o_m_axis_tlast !== e.last ||
                    o_m_axis_tuser !== e.ovf) begin
                    $display("%0t token mismatch: expected id %h last %b ovf %b, got %h %b %b",
                             $time, e.tok, e.last, e.ovf, o_m_axis_tdata, o_m_axis_tlast,
                             o_m_axis_tuser);
                    errors++;
                end
            end
        end
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = 800;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin
        t_row dir_tbl[$];
        int   wait_cnt;
        dir_tbl = '{
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h41, 1, 12'h041},
            '{bpme_pkg::KIND_BYTE,  4095,  4095,  4095,  8'hff, 1, 12'h0ff},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h00, 1, 12'h000},
            '{KIND_UNUSED,          4095,  4095,  4095,  8'hff, 1, -1},
            '{bpme_pkg::KIND_RULE,  'h061, 'h062, 'hfff, 0,     0, -1},
            '{bpme_pkg::KIND_RULE,  'h062, 'h063, 'h100, 0,     0, -1},
            '{bpme_pkg::KIND_RULE,  'hfff, 'h063, 'h101, 0,     0, -1},
            '{bpme_pkg::KIND_RULE,  'h062, 'h063, 'h102, 0,     0, -1},
            '{bpme_pkg::KIND_RULE,  'h000, 'h000, 'h103, 0,     0, -1},
            '{bpme_pkg::KIND_RULE,  'hfff, 'hfff, 'h000, 0,     0, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h61, 0, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h62, 0, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h63, 0, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h62, 0, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h63, 1, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h00, 0, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h00, 0, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h00, 1, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h61, 0, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h62, 0, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h61, 0, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h62, 1, -1},
            '{bpme_pkg::KIND_CLEAR, 0,     0,     0,     0,     0, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h61, 0, -1},
            '{bpme_pkg::KIND_BYTE,  0,     0,     0,     8'h62, 1, -1}
        };

        // reset
        repeat (3) @(posedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done = 1;
        @(posedge i_clk);

        // directed table
        foreach (dir_tbl[i])
            send(dir_tbl[i].kind, dir_tbl[i].lid, dir_tbl[i].rid, dir_tbl[i].mid,
                 dir_tbl[i].bval, dir_tbl[i].last, dir_tbl[i].exp_tok);

        // long word: fills the buffer, then overflows with the last two bytes dropped
        send(bpme_pkg::KIND_RULE, 'h061, 'h061, 'h100, 0, 0);
        send(bpme_pkg::KIND_RULE, 'h100, 'h100, 'h101, 0, 0);
        for (int k = 0; k < WORD_MX + 2; k++)
            send(bpme_pkg::KIND_BYTE, 0, 0, 0, (k % 3 == 2) ? 'h62 : 'h61,
                 k == WORD_MX + 1);

        // ranks: lower ranks merge first across the word
        send(bpme_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
        send(bpme_pkg::KIND_RULE, 'h061, 'h062, 'h100, 0, 0);
        send(bpme_pkg::KIND_RULE, 'h063, 'h064, 'h101, 0, 0);
        send(bpme_pkg::KIND_RULE, 'h065, 'h066, 'h102, 0, 0);
        send(bpme_pkg::KIND_RULE, 'h101, 'h100, 'h103, 0, 0);
        send(bpme_pkg::KIND_BYTE, 0, 0, 0, 'h65, 0);
        send(bpme_pkg::KIND_BYTE, 0, 0, 0, 'h66, 0);
        send(bpme_pkg::KIND_BYTE, 0, 0, 0, 'h63, 0);
        send(bpme_pkg::KIND_BYTE, 0, 0, 0, 'h64, 0);
        send(bpme_pkg::KIND_BYTE, 0, 0, 0, 'h61, 0);
        send(bpme_pkg::KIND_BYTE, 0, 0, 0, 'h62, 1);
        send(bpme_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);

        // random phases: no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 13 : 66) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 13 : 66) : 0;
            id_pool = {};
            for (int c = 'h61; c <= 'h66; c++) id_pool = {id_pool, ID_W'(c)};
            if ($urandom_range(1)) send(bpme_pkg::KIND_CLEAR, 0, 0, 0, 0, 0);
            for (int k = 0; k < 5; k++) begin
                logic [ID_W-1:0] t;
                t = (k == 4) ? ID_W'($urandom_range(4095)) : ID_W'(12'h100 + ph * 16 + k);
                send(bpme_pkg::KIND_RULE, pick_id(), pick_id(), int'(t), 0, 0);
                id_pool = {id_pool, t};
            end
            if (ph == 0) begin
                hold_req++;
                send_word(4, 1'b1);
            end
            for (int k = 0; k < 3; k++) begin
                case ($urandom_range(9))
                    0: send(KIND_UNUSED, $urandom_range(4095), $urandom_range(4095),
                            $urandom_range(4095), $urandom_range(255),
                            1'($urandom_range(1)));
                    1: send(bpme_pkg::KIND_RULE, pick_id(), pick_id(),
                            $urandom_range(4095), 0, 0);
                    2: send_word($urandom_range(5, 1), 1'b0);
                    default: send_word($urandom_range(6, 1), 1'b1);
                endcase
            end
        end
        s_valid <= 1'b0;

        // drain
        wait_cnt = 0;
        while (token_expect_q.size() != 0 && wait_cnt < 2_000_000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (200) @(posedge i_clk);
        if (errors == 0 && token_expect_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: byte_pair_merge_encoder_top.f
hdl/bpme_pkg.sv
hdl/byte_pair_merge_encoder_top.sv
bench/tb.sv
